// ----- rtl/fpba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the fit-policy block allocator.
// No dependencies; imported by every module under rtl/.
package fpba_pkg;

    // Default sizing of the free-size table.
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed port field widths.
    localparam int IDX_W    = 4;
    localparam int SIZE_W   = 16;
    localparam int POL_W    = 2;
    localparam int ACTIVE_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Placement rule codes; the unused code behaves as first fit.
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLOCKS = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [POL_W-1:0]    POLICY_RST = POL_FIRST;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

    // Item modes.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHARGE
    } t_state;

    // Verdict of the shared compare unit for one table entry.
    typedef struct packed {
        logic fits;
        logic take;
    } t_cmp_res;

endpackage

// ----- rtl/fit_policy_block_allocator_core.sv -----
`timescale 1ns / 1ps
// Top level of the fit-policy block allocator: sequencer, scan registers,
// output register. Depends on fpba_pkg, fpba_mem and fpba_cmp.
//
// Usage
//   Input channel (i_valid / o_ready) carries one word: i_mode, i_block_index,
//   i_size_value. A load word (mode 0) writes one entry of the free-size table
//   in the accept cycle and produces no result. A request word (mode 1) scans
//   entries 0 .. active_blocks-1 through one compare unit, one entry a cycle,
//   picks an entry under the fit policy, charges it and returns one result word
//   on the output channel (o_valid / i_ready): o_granted, o_chosen_block,
//   o_remaining_size (zeros when not granted).
//   Sequence: a load is written at accept. A request steps through accept, one
//   table read per entry, a compare of the last read, and a charge that loads
//   the output register. The single read port of the table sets the scan rate.
//   o_ready is high only while the sequencer is idle; one request is in flight
//   at a time.
//   Stall: the result sits in an output register; the sequencer returns to
//   idle and takes the next word while the result waits. A second result
//   holds in the charge step until the output register frees.
//   Configuration port (i_cfg_valid / o_cfg_ready, always ready): index 0 is
//   fit_policy, index 1 is active_blocks; write only while idle.
//   Reset (synchronous, active low) sets first fit, 16 active entries and
//   clears all handshake state. Table contents stay undefined until loaded.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [IDX_W-1:0]      i_block_index,
    input  logic [SIZE_W-1:0]     i_size_value,
    // output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_granted,
    output logic [IDX_W-1:0]      o_chosen_block,
    output logic [SIZE_W-1:0]     o_remaining_size,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    // Sequencer
    t_state r_state, n_state;

    // Configuration registers
    logic [POL_W-1:0]    r_policy;
    logic [ACTIVE_W-1:0] r_active;

    // Request and scan registers
    logic [SIZE_BITS-1:0] r_req;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_ptr;
    logic                 r_chk;
    logic [IW-1:0]        r_chk_idx;
    logic                 r_found;
    logic [IW-1:0]        r_best_idx;
    logic [SIZE_BITS-1:0] r_best_val;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_granted;
    logic [IDX_W-1:0]     r_out_block;
    logic [SIZE_W-1:0]    r_out_rem;

    // Control decoded from the state
    logic w_in_acc, w_ld, w_req_acc;
    logic w_rd_en, w_charge, w_out_free;
    logic w_mem_we;
    logic [IW-1:0]        w_mem_waddr;
    logic [SIZE_BITS-1:0] w_mem_wdata;
    logic [SIZE_BITS-1:0] w_rdata;
    logic [SIZE_BITS-1:0] w_remain;
    logic [CW-1:0]        w_count;
    logic [31:0]          w_idx32, w_size32, w_rem32, w_pick32;
    logic [IW-1:0]        w_ld_addr;
    logic                 w_ld_in_range;
    t_cmp_res             w_cmp;

    // ------------------------------------------------------------------
    // Input word decode
    // ------------------------------------------------------------------
    assign w_in_acc  = i_valid && o_ready;
    assign w_idx32   = 32'(i_block_index);
    assign w_size32  = 32'(i_size_value);
    assign w_ld_addr = w_idx32[IW-1:0];
    assign w_ld_in_range = (w_idx32 < MAX_BLOCKS);
    // Drop loads aimed past the table.
    assign w_ld      = w_in_acc && (i_mode == MODE_LOAD) && w_ld_in_range;
    assign w_req_acc = w_in_acc && (i_mode == MODE_REQUEST);

    // Saturate the active count to the table depth.
    always_comb begin
        if (32'(r_active) > MAX_BLOCKS) begin
            w_count = CW'(MAX_BLOCKS);
        end else begin
            w_count = CW'(r_active);
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_RST;
            r_active <= ACTIVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIT_POLICY:    r_policy <= i_cfg_data[POL_W-1:0];
                CFG_ACTIVE_BLOCKS: r_active <= i_cfg_data[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The last read compares in the same cycle as the exit.
                if (r_ptr >= r_count) begin
                    n_state = ST_CHARGE;
                end
            end
            ST_CHARGE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        o_ready  = 1'b0;
        w_rd_en  = 1'b0;
        w_charge = 1'b0;
        case (r_state)
            ST_IDLE:   o_ready  = 1'b1;
            ST_SCAN:   w_rd_en  = (r_ptr < r_count);
            ST_CHARGE: w_charge = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Free-size table: loads write while idle, the charge writes on exit
    // ------------------------------------------------------------------
    assign w_remain = r_best_val - r_req;

    always_comb begin
        if (w_charge) begin
            w_mem_we    = r_found;
            w_mem_waddr = r_best_idx;
            w_mem_wdata = w_remain;
        end else begin
            w_mem_we    = w_ld;
            w_mem_waddr = w_ld_addr;
            w_mem_wdata = w_size32[SIZE_BITS-1:0];
        end
    end

    fpba_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (SIZE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_ptr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    fpba_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .i_value  (w_rdata),
        .i_req    (r_req),
        .i_best   (r_best_val),
        .i_found  (r_found),
        .i_policy (r_policy),
        .o_res    (w_cmp)
    );

    // ------------------------------------------------------------------
    // Scan registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk   <= 1'b0;
            r_found <= 1'b0;
            r_ptr   <= '0;
            r_count <= '0;
        end else begin
            r_chk <= w_rd_en;
            if (w_req_acc) begin
                r_ptr   <= '0;
                r_count <= w_count;
                r_found <= 1'b0;
            end else begin
                if (w_rd_en) begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (r_chk && w_cmp.take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Payload side of the scan: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_req <= w_size32[SIZE_BITS-1:0];
        end
        if (w_rd_en) begin
            r_chk_idx <= r_ptr[IW-1:0];
        end
        if (r_chk && w_cmp.take) begin
            r_best_idx <= r_chk_idx;
            r_best_val <= w_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign w_rem32  = 32'(w_remain);
    assign w_pick32 = 32'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_charge) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_charge) begin
            r_out_granted <= r_found;
            r_out_block   <= r_found ? w_pick32[IDX_W-1:0] : '0;
            r_out_rem     <= r_found ? w_rem32[SIZE_W-1:0] : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_granted        = r_out_granted;
    assign o_chosen_block   = r_out_block;
    assign o_remaining_size = r_out_rem;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A refused word never leaves a nonzero block or size behind.
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_chosen_block == '0 && o_remaining_size == '0))
        else $error("not-granted result carries nonzero fields");

    // The read pointer never runs past the saturated count.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_ptr <= r_count))
        else $error("scan pointer beyond active count");

    // Any pick held during scan or charge must fit the request.
    a_pick_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && (r_state == ST_SCAN || r_state == ST_CHARGE))
            |-> (r_best_val >= r_req))
        else $error("picked entry smaller than the request");

    // An accepted request closes the input channel on the next cycle.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_mode == MODE_REQUEST) |=> !o_ready)
        else $error("input reopened while a request is in flight");

endmodule

// ----- rtl/fpba_mem.sv -----
`timescale 1ns / 1ps
// Free-size table: one write port, one read port with registered read data.
// Depends on fpba_pkg for the default depth and width.
module fpba_mem
    import fpba_pkg::*;
#(
    parameter int DEPTH = MAX_BLOCKS_DEF,
    parameter int WIDTH = SIZE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fpba_cmp.sv -----
`timescale 1ns / 1ps
// Shared compare unit: judges one table entry against the request and the
// current pick under the active placement rule. Depends on fpba_pkg.
module fpba_cmp
    import fpba_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic [SIZE_BITS-1:0] i_value,
    input  logic [SIZE_BITS-1:0] i_req,
    input  logic [SIZE_BITS-1:0] i_best,
    input  logic                 i_found,
    input  logic [POL_W-1:0]     i_policy,
    output t_cmp_res             o_res
);

    logic w_better;

    // Strict compares keep ties on the lower index.
    always_comb begin
        case (i_policy)
            POL_BEST:  w_better = (i_value < i_best);
            POL_WORST: w_better = (i_value > i_best);
            default:   w_better = 1'b0;
        endcase
    end

    always_comb begin
        o_res.fits = (i_value >= i_req);
        o_res.take = o_res.fits && (!i_found || w_better);
    end

endmodule
